FILE: rtl/pdcr_pkg.sv
`timescale 1ns / 1ps

package pdcr_pkg;

    // Widths of the fixed fields.
    localparam int CMD_W        = 2;
    localparam int CL_W         = 8;
    localparam int ROW_W        = 5;
    localparam int BITS_W       = 16;
    localparam int RATE_W       = 40;
    localparam int EVT_W        = 32;
    localparam int FRAME_RATE_W = 30;

    // Q16 logarithm layout: 5 integer bits, 16 fraction bits.
    localparam int N_W    = 5;
    localparam int FRAC_W = 16;
    localparam int LOG_W  = N_W + FRAC_W;

    localparam logic [15:0] LN2_Q16  = 16'd45426;
    localparam logic [15:0] HALF_Q16 = 16'd32768;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_FRAME  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_EVENT  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REPORT = 2'd2;

    // Register file.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_FRAME_RATE = 1'b0;
    localparam logic [FRAME_RATE_W-1:0] FRAME_RATE_RESET = 30'd4166667;

    // Control from the sequencer to the merging stage.
    typedef struct packed {
        logic clear;
        logic row_wr;
        logic finish;
    } t_mrg_cmd;

endpackage

FILE: rtl/pdcr_lane.sv
`timescale 1ns / 1ps

module pdcr_lane #(
    parameter int COUNT_BITS = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [COUNT_BITS-1:0]               i_count,
    input  logic [pdcr_pkg::EVT_W-1:0]          i_events,
    input  logic [pdcr_pkg::FRAME_RATE_W-1:0]   i_frame_rate,
    output logic                                o_busy,
    output logic [pdcr_pkg::RATE_W-1:0]         o_rate
);
    import pdcr_pkg::*;

    localparam int CMP_W = (COUNT_BITS > EVT_W) ? COUNT_BITS : EVT_W;
    localparam int P1_W  = LOG_W + 16;
    localparam int P2_W  = FRAME_RATE_W + LOG_W;

    localparam logic [2:0] L_IDLE = 3'd0;
    localparam logic [2:0] L_LZC  = 3'd1;
    localparam logic [2:0] L_NORM = 3'd2;
    localparam logic [2:0] L_SQ   = 3'd3;
    localparam logic [2:0] L_D    = 3'd4;
    localparam logic [2:0] L_LN   = 3'd5;
    localparam logic [2:0] L_MUL  = 3'd6;
    localparam logic [2:0] L_RND  = 3'd7;

    logic [2:0]          r_state;
    logic                r_ph;
    logic [EVT_W-1:0]    r_ev;
    logic [EVT_W-1:0]    r_x2;
    logic [N_W-1:0]      r_n;
    logic [EVT_W-1:0]    r_m;
    logic [FRAC_W-1:0]   r_frac;
    logic [3:0]          r_it;
    logic [LOG_W-1:0]    r_la;
    logic [LOG_W-1:0]    r_lb;
    logic [P1_W-1:0]     r_p1;
    logic [LOG_W-1:0]    r_lnq;
    logic [P2_W-1:0]     r_p2;
    logic [RATE_W-1:0]   r_rate;

    logic [CMP_W-1:0]    diff;
    logic                zero;
    logic [EVT_W-1:0]    cur;
    logic [N_W-1:0]      top;
    logic [63:0]         prod;
    logic [EVT_W:0]      sq;
    logic                fbit;
    logic [FRAC_W-1:0]   n_frac;
    logic [LOG_W-1:0]    d;
    logic [P1_W-1:0]     p1_rnd;
    logic [P2_W-1:0]     p2_rnd;

    assign diff  = CMP_W'(i_events) - CMP_W'(i_count);
    assign zero  = (i_events == '0) || (CMP_W'(i_count) >= CMP_W'(i_events));
    assign cur   = r_ph ? r_x2 : r_ev;

    // Index of the top set bit.
    always_comb begin
        top = '0;
        for (int i = 0; i < EVT_W; i++) begin
            if (cur[i]) begin
                top = N_W'(i);
            end
        end
    end

    assign prod   = 64'(r_m) * 64'(r_m);
    assign sq     = prod[63:31];
    assign fbit   = sq[EVT_W];
    assign n_frac = {r_frac[FRAC_W-2:0], fbit};
    assign d      = (r_la > r_lb) ? (r_la - r_lb) : '0;
    assign p1_rnd = r_p1 + P1_W'(HALF_Q16);
    assign p2_rnd = r_p2 + P2_W'(HALF_Q16);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_ph    <= 1'b0;
        end else begin
            unique case (r_state)
                L_IDLE: begin
                    if (i_start) begin
                        r_ev <= i_events;
                        r_x2 <= diff[EVT_W-1:0];
                        r_ph <= 1'b0;
                        if (zero) begin
                            r_rate <= '0;
                        end else begin
                            r_state <= L_LZC;
                        end
                    end
                end
                L_LZC: begin
                    r_n     <= top;
                    r_state <= L_NORM;
                end
                L_NORM: begin
                    r_m     <= cur << (N_W'(EVT_W - 1) - r_n);
                    r_frac  <= '0;
                    r_it    <= '0;
                    r_state <= L_SQ;
                end
                L_SQ: begin
                    r_m    <= fbit ? sq[EVT_W:1] : sq[EVT_W-1:0];
                    r_frac <= n_frac;
                    r_it   <= r_it + 4'd1;
                    if (r_it == 4'd15) begin
                        if (!r_ph) begin
                            r_la    <= {r_n, n_frac};
                            r_ph    <= 1'b1;
                            r_state <= L_LZC;
                        end else begin
                            r_lb    <= {r_n, n_frac};
                            r_state <= L_D;
                        end
                    end
                end
                L_D: begin
                    r_p1    <= P1_W'(d) * P1_W'(LN2_Q16);
                    r_state <= L_LN;
                end
                L_LN: begin
                    r_lnq   <= p1_rnd[P1_W-1:16];
                    r_state <= L_MUL;
                end
                L_MUL: begin
                    r_p2    <= P2_W'(i_frame_rate) * P2_W'(r_lnq);
                    r_state <= L_RND;
                end
                L_RND: begin
                    r_rate  <= RATE_W'(p2_rnd[P2_W-1:16]);
                    r_state <= L_IDLE;
                end
                default: begin
                    r_state <= L_IDLE;
                end
            endcase
        end
    end

    assign o_busy = (r_state != L_IDLE);
    assign o_rate = r_rate;

endmodule

FILE: rtl/pdcr_merge.sv
`timescale 1ns / 1ps

module pdcr_merge #(
    parameter int PIXELS_PER_ROW   = 16,
    parameter int ROWS_PER_CLUSTER = 26
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  pdcr_pkg::t_mrg_cmd                          i_cmd,
    input  logic [PIXELS_PER_ROW*pdcr_pkg::RATE_W-1:0]  i_rates,
    output logic                                        o_busy,
    output logic [pdcr_pkg::RATE_W-1:0]                 o_median,
    output logic [pdcr_pkg::RATE_W-1:0]                 o_mean
);
    import pdcr_pkg::*;

    localparam int PIX    = PIXELS_PER_ROW * ROWS_PER_CLUSTER;
    localparam int SUM_W  = RATE_W + $clog2(PIX);
    localparam int CNT_W  = $clog2(PIX + 1);
    localparam int RA_W   = (ROWS_PER_CLUSTER > 1) ? $clog2(ROWS_PER_CLUSTER) : 1;
    localparam int RD_W   = $clog2(ROWS_PER_CLUSTER + 3);
    localparam int LN_W   = $clog2(PIXELS_PER_ROW + 1);
    localparam int RW_W   = PIXELS_PER_ROW * RATE_W;
    localparam logic [CNT_W-1:0] K_LO = CNT_W'((PIX - 1) / 2);
    localparam logic [CNT_W-1:0] K_HI = CNT_W'(PIX / 2);
    localparam logic [RATE_W-1:0] MSB_MASK = {1'b1, {(RATE_W-1){1'b0}}};

    // The mean is the sum times a rounded-up reciprocal of the pixel count,
    // shifted down. The product is built from four half-width partial
    // products, one per cycle.
    localparam int RS    = SUM_W + $clog2(PIX);
    localparam int HW    = (SUM_W + 3) / 2;
    localparam int ACC_W = 4 * HW;
    localparam logic [ACC_W-1:0] RCP =
        ACC_W'(((ACC_W'(1) << RS) + ACC_W'(PIX - 1)) / ACC_W'(PIX));

    localparam logic [1:0] M_IDLE = 2'd0;
    localparam logic [1:0] M_SUM  = 2'd1;
    localparam logic [1:0] M_SEL  = 2'd2;
    localparam logic [1:0] M_DIV  = 2'd3;

    logic [RW_W-1:0]           scratch [ROWS_PER_CLUSTER];
    logic [RW_W-1:0]           r_sdata;

    logic [1:0]                r_state;
    logic [RA_W-1:0]           r_wptr;
    logic [RW_W-1:0]           r_shift;
    logic [LN_W-1:0]           r_lane;
    logic [SUM_W-1:0]          r_sum;
    logic [RD_W-1:0]           r_rptr;
    logic                      r_v1;
    logic                      r_v2;
    logic [PIXELS_PER_ROW-1:0] r_match;
    logic [CNT_W-1:0]          r_cnt;
    logic [CNT_W-1:0]          r_k;
    logic                      r_ph;
    logic [RATE_W-1:0]         r_pref;
    logic [RATE_W-1:0]         r_hmask;
    logic [RATE_W-1:0]         r_bmask;
    logic [RATE_W-1:0]         r_lo;
    logic [RATE_W-1:0]         r_med;
    logic [ACC_W-1:0]          r_acc;
    logic [1:0]                r_dcnt;

    logic [RA_W-1:0]           raddr;
    logic                      rd_on;
    logic                      sel_end;
    logic                      take1;
    logic [RATE_W-1:0]         n_pref;
    logic [PIXELS_PER_ROW-1:0] match;
    logic [2*HW-1:0]           dvd_x;
    logic [HW-1:0]             mul_a;
    logic [HW-1:0]             mul_b;
    logic [2*HW-1:0]           mul_p;
    logic [ACC_W-1:0]          mul_term;

    assign rd_on   = (r_state == M_SEL) && (r_rptr < RD_W'(ROWS_PER_CLUSTER));
    assign raddr   = rd_on ? r_rptr[RA_W-1:0] : '0;
    assign sel_end = (r_rptr == RD_W'(ROWS_PER_CLUSTER + 2));
    assign take1   = !(r_k < r_cnt);
    assign n_pref  = take1 ? (r_pref | r_bmask) : r_pref;

    // Step 0 takes low by low, steps 1 and 2 the cross terms, step 3 high by
    // high.
    assign dvd_x = (2*HW)'(r_sum);
    assign mul_a = r_dcnt[1] ? dvd_x[2*HW-1:HW] : dvd_x[HW-1:0];
    assign mul_b = r_dcnt[0] ? RCP[2*HW-1:HW] : RCP[HW-1:0];
    assign mul_p = (2*HW)'(mul_a) * (2*HW)'(mul_b);

    always_comb begin
        mul_term = ACC_W'(mul_p);
        if (r_dcnt[1] && r_dcnt[0]) begin
            mul_term = ACC_W'(mul_p) << (2*HW);
        end else if (r_dcnt[1] || r_dcnt[0]) begin
            mul_term = ACC_W'(mul_p) << HW;
        end
    end

    // A value counts when it shares the decided upper bits and has a zero at
    // the bit under test.
    always_comb begin
        for (int p = 0; p < PIXELS_PER_ROW; p++) begin
            match[p] = (((r_sdata[p*RATE_W +: RATE_W] ^ r_pref) & r_hmask) == '0) &&
                       ((r_sdata[p*RATE_W +: RATE_W] & r_bmask) == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.row_wr) begin
            scratch[r_wptr] <= i_rates;
        end
        r_sdata <= scratch[raddr];
        r_match <= match;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
        end else begin
            r_v1 <= rd_on;
            r_v2 <= r_v1;
            if (r_v2) begin
                r_cnt <= r_cnt + CNT_W'($countones(r_match));
            end
            unique case (r_state)
                M_IDLE: begin
                    if (i_cmd.clear) begin
                        r_sum  <= '0;
                        r_wptr <= '0;
                    end else if (i_cmd.row_wr) begin
                        r_wptr  <= r_wptr + 1'b1;
                        r_shift <= i_rates;
                        r_lane  <= '0;
                        r_state <= M_SUM;
                    end else if (i_cmd.finish) begin
                        r_ph    <= 1'b0;
                        r_k     <= K_LO;
                        r_pref  <= '0;
                        r_hmask <= '0;
                        r_bmask <= MSB_MASK;
                        r_rptr  <= '0;
                        r_cnt   <= '0;
                        r_state <= M_SEL;
                    end
                end
                M_SUM: begin
                    r_sum   <= r_sum + SUM_W'(r_shift[RATE_W-1:0]);
                    r_shift <= r_shift >> RATE_W;
                    r_lane  <= r_lane + 1'b1;
                    if (r_lane == LN_W'(PIXELS_PER_ROW - 1)) begin
                        r_state <= M_IDLE;
                    end
                end
                M_SEL: begin
                    if (sel_end) begin
                        r_rptr <= '0;
                        r_cnt  <= '0;
                        if (r_bmask[0]) begin
                            if (!r_ph) begin
                                r_lo    <= n_pref;
                                r_ph    <= 1'b1;
                                r_k     <= K_HI;
                                r_pref  <= '0;
                                r_hmask <= '0;
                                r_bmask <= MSB_MASK;
                            end else begin
                                r_med   <= RATE_W'(((RATE_W+1)'(r_lo) +
                                                    (RATE_W+1)'(n_pref)) >> 1);
                                r_acc   <= '0;
                                r_dcnt  <= '0;
                                r_state <= M_DIV;
                            end
                        end else begin
                            r_pref  <= n_pref;
                            r_k     <= take1 ? (r_k - r_cnt) : r_k;
                            r_hmask <= r_hmask | r_bmask;
                            r_bmask <= r_bmask >> 1;
                        end
                    end else begin
                        r_rptr <= r_rptr + 1'b1;
                    end
                end
                M_DIV: begin
                    r_acc  <= r_acc + mul_term;
                    r_dcnt <= r_dcnt + 2'd1;
                    if (r_dcnt == 2'd3) begin
                        r_state <= M_IDLE;
                    end
                end
                default: begin
                    r_state <= M_IDLE;
                end
            endcase
        end
    end

    assign o_busy   = (r_state != M_IDLE);
    assign o_median = r_med;
    assign o_mean   = r_acc[RS +: RATE_W];

endmodule

FILE: rtl/pixel_dark_count_rate_stats_core.sv
`timescale 1ns / 1ps

// Dark count rate statistics for a photon-counting pixel array.
// Input channel (i_in_valid / o_in_stall): one beat is a command. A frame word
// adds one to the fire counter of every set pixel of one row of one cluster
// with a read and write back of one counter row. An end-of-event beat bumps
// the event total. A report beat computes, for every pixel of the cluster,
// rate = frame_rate * -ln(1 - count/events) in Q16 and returns one beat with
// the median and mean rate in whole hertz. For a report, each lane runs two
// iterative logarithms on its own squaring multiplier, one counter row after
// another; then the two order statistics walk the scratch memory once per
// result bit, and the mean is a reciprocal multiplication built from four
// partial products. Items are handled one at a time.
// Output channel (o_out_valid / i_out_stall): the result sits in an output
// register; frame and event beats are still taken while it waits. If the
// receiver stalls, a following report holds at its end until the register
// frees up. After reset the counter memory is cleared one row per cycle,
// all NUM_CLUSTERS*ROWS_PER_CLUSTER rows (4212 by default), with o_in_stall
// high; register writes are accepted meanwhile.

module pixel_dark_count_rate_stats_core #(
    parameter int NUM_CLUSTERS     = 162,
    parameter int ROWS_PER_CLUSTER = 26,
    parameter int PIXELS_PER_ROW   = 16,
    parameter int COUNT_BITS       = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pdcr_pkg::PADDR_W-1:0]    paddr,
    input  logic [pdcr_pkg::PDATA_W-1:0]    pwdata,
    output logic [pdcr_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready,

    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [pdcr_pkg::CMD_W-1:0]      i_cmd,
    input  logic [pdcr_pkg::CL_W-1:0]       i_cluster_index,
    input  logic [pdcr_pkg::ROW_W-1:0]      i_row_index,
    input  logic [pdcr_pkg::BITS_W-1:0]     i_pixel_bits,

    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [pdcr_pkg::CL_W-1:0]       o_report_cluster,
    output logic [pdcr_pkg::RATE_W-1:0]     o_median_rate_hz,
    output logic [pdcr_pkg::RATE_W-1:0]     o_mean_rate_hz
);
    import pdcr_pkg::*;

    localparam int TOTAL_ROWS = NUM_CLUSTERS * ROWS_PER_CLUSTER;
    localparam int ROW_AW     = (TOTAL_ROWS > 1) ? $clog2(TOTAL_ROWS) : 1;
    localparam int RP_W       = (ROWS_PER_CLUSTER > 1) ? $clog2(ROWS_PER_CLUSTER) : 1;
    localparam int FW         = PIXELS_PER_ROW * COUNT_BITS;
    localparam int IDX_W      = 16;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [EVT_W-1:0]      EVT_MAX   = '1;

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_FRD   = 4'd2;
    localparam logic [3:0] ST_RRD   = 4'd3;
    localparam logic [3:0] ST_RST   = 4'd4;
    localparam logic [3:0] ST_RWT   = 4'd5;
    localparam logic [3:0] ST_FIN   = 4'd6;
    localparam logic [3:0] ST_MWT   = 4'd7;
    localparam logic [3:0] ST_OUT   = 4'd8;

    // Counter memory: one word holds the counters of one pixel row.
    logic [FW-1:0]             fire_mem [TOTAL_ROWS];
    logic [FW-1:0]             r_rdata;

    logic [3:0]                r_state;
    logic [ROW_AW-1:0]         r_addr;
    logic [RP_W-1:0]           r_row_ptr;
    logic [CL_W-1:0]           r_cl;
    logic [BITS_W-1:0]         r_bits;
    logic [EVT_W-1:0]          r_events;
    logic [FRAME_RATE_W-1:0]   r_frame_rate;
    logic                      r_out_valid;
    logic [CL_W-1:0]           r_out_cl;
    logic [RATE_W-1:0]         r_out_med;
    logic [RATE_W-1:0]         r_out_mean;

    logic                      in_acc;
    logic [IDX_W-1:0]          in_base;
    logic [IDX_W-1:0]          in_idx;
    logic                      cl_ok;
    logic                      row_ok;
    logic                      out_free;
    logic                      cfg_wr;
    logic                      reg_sel;
    logic [ROW_AW-1:0]         mem_raddr;
    logic                      mem_we;
    logic [FW-1:0]             upd_row;
    logic [FW-1:0]             mem_wdata;
    logic                      lane_start;
    logic [PIXELS_PER_ROW-1:0] lane_busy;
    logic                      lanes_idle;
    logic [PIXELS_PER_ROW*RATE_W-1:0] lane_rates;
    t_mrg_cmd                  mrg_cmd;
    logic                      mrg_busy;
    logic [RATE_W-1:0]         mrg_median;
    logic [RATE_W-1:0]         mrg_mean;

    // Register port. The user must write only while the block is idle; the block itself does not enforce this.
    assign pready  = 1'b1;
    assign reg_sel = paddr[PADDR_W-1];
    assign cfg_wr  = psel && penable && pwrite && (reg_sel == REG_FRAME_RATE);
    assign prdata  = (reg_sel == REG_FRAME_RATE) ? PDATA_W'(r_frame_rate) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_rate <= FRAME_RATE_RESET;
        end else if (cfg_wr) begin
            r_frame_rate <= pwdata[FRAME_RATE_W-1:0];
        end
    end

    // Input decode. Row address of a cluster is cluster * rows + row.
    assign o_in_stall = (r_state != ST_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign in_base    = IDX_W'(i_cluster_index) * IDX_W'(ROWS_PER_CLUSTER);
    assign in_idx     = in_base + IDX_W'(i_row_index);
    assign cl_ok      = IDX_W'(i_cluster_index) < IDX_W'(NUM_CLUSTERS);
    assign row_ok     = IDX_W'(i_row_index) < IDX_W'(ROWS_PER_CLUSTER);
    assign out_free   = !r_out_valid || !i_out_stall;

    // Saturating increment lanes for a frame word. Mask bits beyond the row
    // width, or beyond the sixteen mask bits, never fire.
    for (genvar p = 0; p < PIXELS_PER_ROW; p++) begin : g_inc
        logic [COUNT_BITS-1:0] cnt;
        logic                  fire;
        if (p < BITS_W) begin : g_bit
            assign fire = r_bits[p];
        end else begin : g_none
            assign fire = 1'b0;
        end
        assign cnt = r_rdata[p*COUNT_BITS +: COUNT_BITS];
        assign upd_row[p*COUNT_BITS +: COUNT_BITS] =
            (fire && (cnt != COUNT_MAX)) ? (cnt + 1'b1) : cnt;
    end

    assign mem_raddr = (r_state == ST_IDLE) ? in_idx[ROW_AW-1:0] : r_addr;
    assign mem_we    = (r_state == ST_CLEAR) || (r_state == ST_FRD);
    assign mem_wdata = (r_state == ST_CLEAR) ? '0 : upd_row;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            fire_mem[r_addr] <= mem_wdata;
        end
        r_rdata <= fire_mem[mem_raddr];
    end

    // One rate lane per pixel of a row; all start on the same counter row.
    assign lane_start = (r_state == ST_RST);
    assign lanes_idle = ~|lane_busy;

    for (genvar p = 0; p < PIXELS_PER_ROW; p++) begin : g_lane
        pdcr_lane #(
            .COUNT_BITS (COUNT_BITS)
        ) u_lane (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_start      (lane_start),
            .i_count      (r_rdata[p*COUNT_BITS +: COUNT_BITS]),
            .i_events     (r_events),
            .i_frame_rate (r_frame_rate),
            .o_busy       (lane_busy[p]),
            .o_rate       (lane_rates[p*RATE_W +: RATE_W])
        );
    end

    // The merging stage stores each finished row, keeps the running sum and
    // later picks the two middle values and divides the sum.
    assign mrg_cmd.clear  = in_acc && (i_cmd == CMD_REPORT) && cl_ok;
    assign mrg_cmd.row_wr = (r_state == ST_RWT) && lanes_idle && !mrg_busy;
    assign mrg_cmd.finish = (r_state == ST_FIN) && !mrg_busy;

    pdcr_merge #(
        .PIXELS_PER_ROW   (PIXELS_PER_ROW),
        .ROWS_PER_CLUSTER (ROWS_PER_CLUSTER)
    ) u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (mrg_cmd),
        .i_rates  (lane_rates),
        .o_busy   (mrg_busy),
        .o_median (mrg_median),
        .o_mean   (mrg_mean)
    );

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_addr   <= '0;
            r_events <= '0;
        end else begin
            unique case (r_state)
                ST_CLEAR: begin
                    r_addr <= r_addr + 1'b1;
                    if (r_addr == ROW_AW'(TOTAL_ROWS - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (in_acc) begin
                        r_cl   <= i_cluster_index;
                        r_bits <= i_pixel_bits;
                        unique case (i_cmd)
                            CMD_FRAME: begin
                                if (cl_ok && row_ok) begin
                                    r_addr  <= in_idx[ROW_AW-1:0];
                                    r_state <= ST_FRD;
                                end
                            end
                            CMD_EVENT: begin
                                if (r_events != EVT_MAX) begin
                                    r_events <= r_events + 1'b1;
                                end
                            end
                            CMD_REPORT: begin
                                if (cl_ok) begin
                                    r_addr    <= in_base[ROW_AW-1:0];
                                    r_row_ptr <= '0;
                                    r_state   <= ST_RRD;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_FRD: begin
                    r_state <= ST_IDLE;
                end
                ST_RRD: begin
                    r_state <= ST_RST;
                end
                ST_RST: begin
                    r_state <= ST_RWT;
                end
                ST_RWT: begin
                    if (lanes_idle && !mrg_busy) begin
                        if (r_row_ptr == RP_W'(ROWS_PER_CLUSTER - 1)) begin
                            r_state <= ST_FIN;
                        end else begin
                            r_row_ptr <= r_row_ptr + 1'b1;
                            r_addr    <= r_addr + 1'b1;
                            r_state   <= ST_RRD;
                        end
                    end
                end
                ST_FIN: begin
                    if (!mrg_busy) begin
                        r_state <= ST_MWT;
                    end
                end
                ST_MWT: begin
                    if (!mrg_busy) begin
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_OUT) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_OUT) && out_free) begin
            r_out_cl   <= r_cl;
            r_out_med  <= mrg_median;
            r_out_mean <= mrg_mean;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_report_cluster = r_out_cl;
    assign o_median_rate_hz = r_out_med;
    assign o_mean_rate_hz   = r_out_mean;

endmodule

FILE: rtl/pdcr_chk.sv
`timescale 1ns / 1ps

module pdcr_chk #(
    parameter int NUM_CLUSTERS = 162
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_stall,
    input logic [pdcr_pkg::CMD_W-1:0]      i_cmd,
    input logic [pdcr_pkg::CL_W-1:0]       i_cluster_index,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input logic [pdcr_pkg::CL_W-1:0]       o_report_cluster,
    input logic [pdcr_pkg::RATE_W-1:0]     o_median_rate_hz,
    input logic [pdcr_pkg::RATE_W-1:0]     o_mean_rate_hz
);
    import pdcr_pkg::*;

    // A stalled result beat stays and holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid &&
        $stable(o_report_cluster) && $stable(o_median_rate_hz) &&
        $stable(o_mean_rate_hz))
        else $error("stalled result beat changed");

    // Reset starts the clearing pass: no input and no result right after.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall && !o_out_valid)
        else $error("input not stalled after reset");

    // A report for an existing cluster keeps the input stalled while it runs.
    a_report_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_cmd == CMD_REPORT) &&
        (32'(i_cluster_index) < 32'(NUM_CLUSTERS)) |=> o_in_stall)
        else $error("report did not hold the input");

    // Only existing clusters are ever reported.
    a_cluster_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_report_cluster) < 32'(NUM_CLUSTERS)))
        else $error("reported cluster out of range");

endmodule

bind pixel_dark_count_rate_stats_core pdcr_chk #(
    .NUM_CLUSTERS (NUM_CLUSTERS)
) u_pdcr_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_stall       (o_in_stall),
    .i_cmd            (i_cmd),
    .i_cluster_index  (i_cluster_index),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_report_cluster (o_report_cluster),
    .o_median_rate_hz (o_median_rate_hz),
    .o_mean_rate_hz   (o_mean_rate_hz)
);
